@@ rtl/utf16_to_utf8_encoder_top_macros.svh @@
// Assertion macros shared by the UTF-16 to UTF-8 encoder.
`ifndef UTF16_TO_UTF8_ENCODER_TOP_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define U16U8_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/u16u8_pkg.sv @@
// Package with types, constants and byte-encoding functions of the encoder.
`timescale 1ns / 1ps
package u16u8_pkg;

    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;
    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam int          QUEUE_DEPTH_DEF = 4;
    localparam logic [2:0]  PRE_LEN       = 3'd3;

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_ENDED   = 2'd2
    } t_status;

    // One decoded unit of work: an optional leftover high surrogate emitted
    // as three bytes, followed by an optional code point or an error result.
    typedef struct packed {
        logic        pre;
        logic [9:0]  pre_bits;
        logic [20:0] cp;
        logic [2:0]  main_len;
        t_status     status;
        logic        end_flag;
    } t_job;

    function automatic logic [2:0] f_utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp < 21'h000080) begin
            len = 3'd1;
        end else if (cp < 21'h000800) begin
            len = 3'd2;
        end else if (cp < SUPP_BASE) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [7:0] f_utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                               input logic [1:0] pos);
        logic [7:0] b;
        b = cp[7:0];
        case (len)
            3'd2: begin
                case (pos)
                    2'd0:    b = {3'b110, cp[10:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd3: begin
                case (pos)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (pos)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = cp[7:0];
        endcase
        return b;
    endfunction

endpackage

@@ rtl/utf16_to_utf8_encoder_top.sv @@
// UTF-16 to UTF-8 encoder: ingest of code units, job queue and byte serializer.
// A unit is written into the job queue and then loaded into the serializer's job register
// before its first byte can transfer. Throughput: one unit per cycle in while the queue has
// room and one byte per cycle out unless stalled; a unit yields 0 to 6 bytes.
// Synchronous active-low reset empties the queue, clears the surrogate and halt state and
// sets strict mode.
`timescale 1ns / 1ps
module utf16_to_utf8_encoder_top #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_last_in_run,
    output logic        o_string_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import u16u8_pkg::*;

    `include "utf16_to_utf8_encoder_top_macros.svh"

    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_valid;
    t_job w_front_job;
    t_job w_q_job;

    assign o_cfg_ready = 1'b1;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_job       (w_front_job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    u16u8_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_job       (w_q_job),
        .i_out_stall   (i_out_stall),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_last_in_run (o_last_in_run),
        .o_string_end  (o_string_end)
    );

    `U16U8_ASSERT_IMPLY(a_err_shape, i_clk, i_rst_n,
        o_out_valid && (o_status != ST_DATA),
        (o_out_byte == 8'h00) && o_last_in_run && o_string_end,
        "error result must be a zero byte that ends the string")
    `U16U8_ASSERT_IMPLY(a_end_is_last, i_clk, i_rst_n,
        o_out_valid && o_string_end, o_last_in_run,
        "string end flagged on a byte that does not end its unit")
    `U16U8_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n,
        w_push, !w_q_full,
        "job pushed into a full queue")
    `U16U8_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_last_in_run, o_out_valid,
        "byte sequence of a unit broken off")

endmodule

@@ rtl/u16u8_front.sv @@
// Front end: accepts code units, tracks surrogate state and builds jobs.
`timescale 1ns / 1ps
module u16u8_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [15:0]        i_code_unit,
    input  logic               i_last_unit,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_data,
    input  logic               i_q_full,
    output logic               o_in_stall,
    output logic               o_push,
    output u16u8_pkg::t_job    o_job
);
    import u16u8_pkg::*;

    logic       r_strict_mode;
    logic       r_held_valid;
    logic       n_held_valid;
    logic [9:0] r_held_bits;
    logic [9:0] n_held_bits;
    logic       r_halted;
    logic       n_halted;
    logic       w_accept;
    logic       w_is_high;
    logic       w_is_low;
    logic       w_err;
    logic       w_done;
    t_job       w_job;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    assign w_is_high  = i_code_unit inside {[HIGH_SURR_MIN:HIGH_SURR_MAX]};
    assign w_is_low   = i_code_unit inside {[LOW_SURR_MIN:LOW_SURR_MAX]};

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        n_halted     = r_halted;
        w_job        = '0;
        w_err        = 1'b0;
        w_done       = 1'b0;
        o_push       = 1'b0;
        if (w_accept) begin
            if (r_halted) begin
                if (i_last_unit) begin
                    n_halted     = 1'b0;
                    n_held_valid = 1'b0;
                    n_held_bits  = '0;
                end
            end else begin
                if (r_held_valid) begin
                    n_held_valid = 1'b0;
                    n_held_bits  = '0;
                    if (w_is_low) begin
                        w_job.cp       = {1'b0, r_held_bits, i_code_unit[9:0]} + SUPP_BASE;
                        w_job.main_len = 3'd4;
                        w_done         = 1'b1;
                    end else if (r_strict_mode) begin
                        w_job.status   = ST_ILLEGAL;
                        w_job.main_len = 3'd1;
                        w_err          = 1'b1;
                        w_done         = 1'b1;
                    end else begin
                        // Lenient: the unpaired high surrogate goes out as a plain value.
                        w_job.pre      = 1'b1;
                        w_job.pre_bits = r_held_bits;
                    end
                end
                if (!w_done) begin
                    if (w_is_high) begin
                        if (i_last_unit) begin
                            w_job.status   = ST_ENDED;
                            w_job.main_len = 3'd1;
                            w_err          = 1'b1;
                        end else begin
                            n_held_valid = 1'b1;
                            n_held_bits  = i_code_unit[9:0];
                        end
                    end else if (w_is_low && r_strict_mode) begin
                        w_job.status   = ST_ILLEGAL;
                        w_job.main_len = 3'd1;
                        w_err          = 1'b1;
                    end else begin
                        w_job.cp       = {5'b0, i_code_unit};
                        w_job.main_len = f_utf8_len({5'b0, i_code_unit});
                    end
                end
                if (w_err) begin
                    n_held_valid = 1'b0;
                    n_held_bits  = '0;
                    if (!i_last_unit) begin
                        n_halted = 1'b1;
                    end
                end
                w_job.end_flag = w_err || i_last_unit;
                o_push         = w_job.pre || (w_job.main_len != 3'd0);
            end
        end
    end

    assign o_job = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict_mode <= 1'b1;
            r_held_valid  <= 1'b0;
            r_held_bits   <= '0;
            r_halted      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_strict_mode <= i_cfg_data;
            end
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
            r_halted     <= n_halted;
        end
    end

endmodule

@@ rtl/u16u8_queue.sv @@
// Small job queue that decouples the front end from the byte serializer.
`timescale 1ns / 1ps
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u16u8_pkg::t_job    i_job,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output u16u8_pkg::t_job    o_job
);
    import u16u8_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/u16u8_back.sv @@
// Back end: holds one job and emits its UTF-8 bytes one transfer at a time.
`timescale 1ns / 1ps
module u16u8_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  u16u8_pkg::t_job    i_q_job,
    input  logic               i_out_stall,
    output logic               o_pop,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic [1:0]         o_status,
    output logic               o_last_in_run,
    output logic               o_string_end
);
    import u16u8_pkg::*;

    logic       r_busy;
    t_job       r_job;
    logic [2:0] r_idx;
    logic [2:0] w_total;
    logic [2:0] w_main_pos;
    logic       w_in_pre;
    logic       w_last_beat;
    logic       w_out_accept;

    assign w_total      = (r_job.pre ? PRE_LEN : 3'd0) + r_job.main_len;
    assign w_in_pre     = r_job.pre && (r_idx < PRE_LEN);
    assign w_main_pos   = r_idx - (r_job.pre ? PRE_LEN : 3'd0);
    assign w_last_beat  = (r_idx == w_total - 3'd1);
    assign w_out_accept = r_busy && !i_out_stall;
    assign o_pop        = i_q_valid && (!r_busy || (w_out_accept && w_last_beat));

    always_comb begin
        o_out_byte = 8'h00;
        o_status   = ST_DATA;
        if (w_in_pre) begin
            o_out_byte = f_utf8_byte({5'b0, HIGH_SURR_TAG, r_job.pre_bits}, PRE_LEN,
                                     r_idx[1:0]);
        end else if (r_job.status != ST_DATA) begin
            o_status = r_job.status;
        end else begin
            o_out_byte = f_utf8_byte(r_job.cp, r_job.main_len, w_main_pos[1:0]);
        end
    end

    assign o_out_valid   = r_busy;
    assign o_last_in_run = w_last_beat;
    assign o_string_end  = w_last_beat && r_job.end_flag;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_out_accept) begin
            if (w_last_beat) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the UTF-16 to UTF-8 encoder top level.
`timescale 1ns / 1ps
module tb_top;
    import u16u8_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_UNITS  = 285;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       run_end;
        logic       str_end;
    } t_utf8_out;

    typedef struct {
        logic [15:0] cu;
        logic        last;
        logic        strict;
        logic        typed;
        t_utf8_out   want;
    } t_dir_row;

    localparam t_utf8_out NO_WANT = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_code_unit = '0;
    logic        i_last_unit = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic        o_last_in_run;
    logic        o_string_end;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    utf16_to_utf8_encoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_code_unit   (i_code_unit),
        .i_last_unit   (i_last_unit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_last_in_run (o_last_in_run),
        .o_string_end  (o_string_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Encoder state as the predictor sees it.
    logic [9:0] held_bits = '0;
    logic       held_valid = 1'b0;
    logic       halted = 1'b0;
    logic       strict_mode = 1'b1;

    t_utf8_out  step_res [0:5];
    int         step_cnt = 0;
    t_utf8_out  utf8_due [$];
    int         err_count = 0;
    int         units_done = 0;
    int         burst_left = 0;

    // Directed strings: extremes of each byte length, surrogate pairs, every error kind,
    // dropping after an error, a mode change with a high surrogate held, and lenient
    // handling of unpaired surrogates up to six bytes from one unit.
    t_dir_row dir_rows [0:24] = '{
        '{16'h0000, 1'b0, 1'b1, 1'b1, '{8'h00, ST_DATA, 1'b1, 1'b0}},
        '{16'h007F, 1'b0, 1'b1, 1'b1, '{8'h7F, ST_DATA, 1'b1, 1'b0}},
        '{16'h0080, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{16'h07FF, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{16'h0800, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{16'hFFFF, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{16'hD800, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{16'hDC00, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{16'hDBFF, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{16'hDFFF, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{16'hDC00, 1'b0, 1'b1, 1'b1, '{8'h00, ST_ILLEGAL, 1'b1, 1'b1}},
        '{16'h0041, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{16'h0042, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{16'hD800, 1'b1, 1'b1, 1'b1, '{8'h00, ST_ENDED, 1'b1, 1'b1}},
        '{16'hD801, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{16'h0041, 1'b0, 1'b1, 1'b1, '{8'h00, ST_ILLEGAL, 1'b1, 1'b1}},
        '{16'hFFFF, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{16'hDABC, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{16'h0041, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{16'hDC00, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{16'hDBFF, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{16'hD800, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{16'hDBFF, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{16'hFFFF, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{16'hD800, 1'b1, 1'b0, 1'b1, '{8'h00, ST_ENDED, 1'b1, 1'b1}}
    };

    function automatic void put_byte(logic [7:0] data, t_status st);
        step_res[step_cnt] = '{data, st, 1'b0, 1'b0};
        step_cnt++;
    endfunction

    function automatic void put_point(logic [20:0] cp);
        if (cp < 21'h000080) begin
            put_byte(cp[7:0], ST_DATA);
        end else if (cp < 21'h000800) begin
            put_byte(8'hC0 | {3'b000, cp[10:6]}, ST_DATA);
            put_byte(8'h80 | {2'b00, cp[5:0]}, ST_DATA);
        end else if (cp < 21'h010000) begin
            put_byte(8'hE0 | {4'b0000, cp[15:12]}, ST_DATA);
            put_byte(8'h80 | {2'b00, cp[11:6]}, ST_DATA);
            put_byte(8'h80 | {2'b00, cp[5:0]}, ST_DATA);
        end else begin
            put_byte(8'hF0 | {5'b00000, cp[20:18]}, ST_DATA);
            put_byte(8'h80 | {2'b00, cp[17:12]}, ST_DATA);
            put_byte(8'h80 | {2'b00, cp[11:6]}, ST_DATA);
            put_byte(8'h80 | {2'b00, cp[5:0]}, ST_DATA);
        end
    endfunction

    // Works out the UTF-8 bytes caused by one code unit and advances the state.
    function automatic void encode_unit(logic [15:0] cu, logic lu);
        logic err;
        logic done;
        logic is_hi;
        logic is_lo;
        err = 1'b0;
        done = 1'b0;
        step_cnt = 0;
        is_hi = (cu >= 16'hD800) && (cu <= 16'hDBFF);
        is_lo = (cu >= 16'hDC00) && (cu <= 16'hDFFF);
        if (halted) begin
            if (lu) begin
                halted = 1'b0;
                held_valid = 1'b0;
                held_bits = '0;
            end
            return;
        end
        if (held_valid) begin
            held_valid = 1'b0;
            if (is_lo) begin
                put_point({1'b0, held_bits, cu[9:0]} + 21'h010000);
                done = 1'b1;
            end else if (strict_mode) begin
                put_byte(8'h00, ST_ILLEGAL);
                err = 1'b1;
                done = 1'b1;
            end else begin
                // The unpaired high surrogate goes out as a plain 16-bit value.
                put_point({5'b00000, 6'b110110, held_bits});
            end
            held_bits = '0;
        end
        if (!done) begin
            if (is_hi) begin
                if (lu) begin
                    put_byte(8'h00, ST_ENDED);
                    err = 1'b1;
                end else begin
                    held_bits = cu[9:0];
                    held_valid = 1'b1;
                end
            end else if (is_lo && strict_mode) begin
                put_byte(8'h00, ST_ILLEGAL);
                err = 1'b1;
            end else begin
                put_point({5'b00000, cu});
            end
        end
        if (err) begin
            held_valid = 1'b0;
            held_bits = '0;
            if (!lu) begin
                halted = 1'b1;
            end
        end
        if (step_cnt > 0) begin
            step_res[step_cnt - 1].run_end = 1'b1;
            step_res[step_cnt - 1].str_end = err || lu;
        end
    endfunction

    function automatic void check_field(string what, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
            err_count++;
        end
    endfunction

    // Holds one unit until its transfer, then books the bytes it must cause.
    task automatic send_unit(input logic [15:0] cu, input logic lu,
                             input logic typed = 1'b0, input t_utf8_out want = '0);
        int gap;
        i_in_valid <= 1'b1;
        i_code_unit <= cu;
        i_last_unit <= lu;
        do @(posedge i_clk); while (o_in_stall);
        encode_unit(cu, lu);
        units_done++;
        if (typed) begin
            utf8_due.push_back(want);
        end else begin
            for (int k = 0; k < step_cnt; k++) begin
                utf8_due.push_back(step_res[k]);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stops sending until every booked byte has come out and the block has settled.
    task automatic drain_out();
        i_in_valid <= 1'b0;
        while (utf8_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic strict);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= strict;
        do @(posedge i_clk); while (!o_cfg_ready);
        strict_mode = strict;
        i_cfg_valid <= 1'b0;
    endtask

    // One random piece of text: mostly well-formed code points and pairs, some noise.
    task automatic send_piece();
        int kind;
        logic [9:0] lo_bits;
        logic [9:0] hi_bits;
        logic [15:0] cu;
        logic lu;
        kind = $urandom_range(0, 99);
        lo_bits = 10'($urandom_range(0, 1023));
        hi_bits = 10'($urandom_range(0, 1023));
        lu = ($urandom_range(0, 7) == 0);
        if (kind < 20) begin
            cu = 16'($urandom_range(16'h0000, 16'h007F));
        end else if (kind < 35) begin
            cu = 16'($urandom_range(16'h0080, 16'h07FF));
        end else if (kind < 55) begin
            cu = 16'($urandom_range(16'h0800, 16'hD7FF));
        end else if (kind < 65) begin
            cu = 16'($urandom_range(16'hE000, 16'hFFFF));
        end else if (kind < 85) begin
            send_unit({6'b110110, hi_bits}, 1'b0);
            cu = {6'b110111, lo_bits};
        end else if (kind < 90) begin
            cu = {6'b110110, hi_bits};
        end else if (kind < 94) begin
            cu = {6'b110111, lo_bits};
        end else begin
            cu = 16'($urandom);
        end
        send_unit(cu, lu);
    endtask

    // The receiver switches at random between four stall patterns.
    int   stall_mode = 0;
    int   stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ~i_out_stall;
        endcase
    end

    always @(posedge i_clk) begin : byte_check
        t_utf8_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (utf8_due.size() == 0) begin
                $display("%0t: byte with nothing expected, expected none, got %02h status %0d",
                         $time, o_out_byte, o_status);
                err_count++;
            end else begin
                want = utf8_due.pop_front();
                check_field("out_byte", want.data, o_out_byte);
                check_field("status", want.status, o_status);
                check_field("last_in_run", want.run_end, o_last_in_run);
                check_field("string_end", want.str_end, o_string_end);
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase_len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b1);

        for (int r = 0; r < 25; r++) begin
            // Mode changes only once the block has gone quiet.
            if (dir_rows[r].strict != strict_mode) begin
                drain_out();
                write_mode(dir_rows[r].strict);
            end
            send_unit(dir_rows[r].cu, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].want);
        end

        units_done = 0;
        while (units_done < RANDOM_UNITS) begin
            drain_out();
            write_mode(1'($urandom_range(0, 1)));
            phase_len = $urandom_range(15, 45);
            for (int p = 0; p < phase_len && units_done < RANDOM_UNITS; p++) begin
                if ($urandom_range(0, 39) == 0) begin
                    drain_out();
                end
                send_piece();
            end
        end

        drain_out();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && utf8_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
